[src/lzx_e8_pkg.sv]
// ----------------------------------------------------------------------------
// lzx_e8_pkg
// Shared constants, result type and call-target translation function for the
// LZX E8 call translation filter.
// ----------------------------------------------------------------------------
package lzx_e8_pkg;

    // Chunk length limit; longer lengths saturate to this
    localparam int MAX_CHUNK_LENGTH = 32768;

    // Call opcode and guard distance from the chunk tail
    localparam logic [7:0]  CALL_OPCODE = 8'hE8;
    localparam logic [16:0] TAIL_GUARD  = 17'd10;

    // Target bytes to collect after a call opcode
    localparam logic [2:0]  TARGET_BYTES = 3'd4;

    // Configuration register indexes
    localparam logic [1:0]  REG_DIRECTION = 2'd0;
    localparam logic [1:0]  REG_FILE_SIZE = 2'd1;

    // Reset value of the file size register
    localparam logic [30:0] FILE_SIZE_RESET = 31'd12000000;

    // Direction codes
    localparam logic        DIR_FORWARD = 1'b0;

    // Output queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       chunk_end;
    } res_t;

    // Translate a 32-bit call target for the call at position pos
    function automatic logic [31:0] e8_translate(
        input logic [31:0] word,
        input logic [15:0] pos,
        input logic [30:0] fs,
        input logic        dir
    );
        logic signed [33:0] v;
        logic signed [33:0] p;
        logic signed [33:0] f;
        logic signed [33:0] r;
        begin
            v = {{2{word[31]}}, word};
            p = {18'b0, pos};
            f = {3'b0, fs};
            r = v;
            if (dir == DIR_FORWARD)
            begin
                // relative to absolute
                if (v >= -p && v < f)
                begin
                    if (v < f - p)
                        r = v + p;
                    else
                        r = v - f;
                end
            end
            else
            begin
                // absolute back to relative
                if (!v[33])
                begin
                    if (v < f)
                        r = v - p;
                end
                else if (v >= -p)
                begin
                    r = v + f;
                end
            end
            return r[31:0];
        end
    endfunction

endpackage

[src/lzx_e8_call_translation.sv]
// ----------------------------------------------------------------------------
// lzx_e8_call_translation
// Byte stream filter that translates the 32-bit targets of E8 call opcodes
// between relative and absolute form, one input byte per cycle.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then translated into
//   the output queue, from which its words leave on the output port.
// Throughput: one input byte per cycle; a completed target yields four output
//   words that drain one per cycle while m_tready is high, from an 8-entry
//   output queue. Input stalls only while more than four words wait in the queue.
// Reset: rst_n clears all position, collection and queue state and sets the
//   registers to forward direction and a file size of 12000000.
module lzx_e8_call_translation
    import lzx_e8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] chunk_length
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] chunk_end
);

    // Configuration registers
    logic        direction_reg;
    logic [30:0] file_size_reg;

    // Input register
    logic        s0_valid_reg;
    logic [7:0]  s0_byte_reg;
    logic [15:0] s0_len_reg;

    // Filter state
    logic [15:0] byte_position_reg, byte_position_next;
    logic [2:0]  pending_count_reg, pending_count_next;
    logic [15:0] call_position_reg, call_position_next;
    logic [23:0] held_target_reg,   held_target_next;

    // Output queue
    res_t                q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] q_wp_reg;
    logic [QUEUE_AW-1:0] q_rp_reg;
    logic [QUEUE_AW:0]   q_count_reg;

    // Per-item decode
    logic        proc;
    logic        pop;
    logic [15:0] len_sat;
    logic        is_end;
    logic        call_ok;
    logic [1:0]  idx;
    logic [31:0] target;
    res_t        res [4];
    logic [2:0]  push_n;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_FORWARD;
            file_size_reg <= FILE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DIRECTION)
                direction_reg <= cfg_data[0];
            else if (cfg_index == REG_FILE_SIZE)
                file_size_reg <= cfg_data;
        end
    end

    // Process the held word when the queue has room for a full burst
    assign proc     = s0_valid_reg && (q_count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 4));
    assign s_tready = !s0_valid_reg || proc;
    assign pop      = m_tvalid && m_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s_tready)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s0_byte_reg <= s_tdata[7:0];
            s0_len_reg  <= s_tdata[23:8];
        end
    end

    // Chunk bookkeeping
    assign len_sat = (s0_len_reg > 16'(MAX_CHUNK_LENGTH)) ? 16'(MAX_CHUNK_LENGTH)
                                                          : s0_len_reg;
    assign is_end  = ({1'b0, byte_position_reg} + 17'd1) >= {1'b0, len_sat};
    assign call_ok = ({1'b0, len_sat} > TAIL_GUARD)
                  && (({1'b0, byte_position_reg} + TAIL_GUARD) < {1'b0, len_sat});
    assign idx     = 2'(TARGET_BYTES - pending_count_reg);
    assign target  = e8_translate({s0_byte_reg, held_target_reg}, call_position_reg,
                                  file_size_reg, direction_reg);

    // Result generation and next state
    always_comb
    begin
        byte_position_next = byte_position_reg;
        pending_count_next = pending_count_reg;
        call_position_next = call_position_reg;
        held_target_next   = held_target_reg;
        push_n             = 3'd0;
        for (int i = 0; i < 4; i++)
            res[i] = '0;

        if (proc)
        begin
            byte_position_next = is_end ? 16'd0 : byte_position_reg + 16'd1;

            if (pending_count_reg == 3'd1)
            begin
                // fourth target byte: emit the translated target
                res[0]             = '{target[7:0],   1'b0, 1'b0};
                res[1]             = '{target[15:8],  1'b0, 1'b0};
                res[2]             = '{target[23:16], 1'b0, 1'b0};
                res[3]             = '{target[31:24], 1'b1, is_end};
                push_n             = 3'd4;
                pending_count_next = 3'd0;
                held_target_next   = '0;
            end
            else if (pending_count_reg != 3'd0 && is_end)
            begin
                // chunk ended mid-target: flush held bytes untranslated
                res[0]             = '{held_target_reg[7:0],   1'b0, 1'b0};
                res[1]             = '{held_target_reg[15:8],  1'b0, 1'b0};
                res[2]             = '{held_target_reg[23:16], 1'b0, 1'b0};
                res[idx]           = '{s0_byte_reg, 1'b1, 1'b1};
                push_n             = {1'b0, idx} + 3'd1;
                pending_count_next = 3'd0;
                held_target_next   = '0;
            end
            else if (pending_count_reg != 3'd0)
            begin
                // collect one target byte
                case (idx)
                    2'd0:    held_target_next[7:0]   = s0_byte_reg;
                    2'd1:    held_target_next[15:8]  = s0_byte_reg;
                    2'd2:    held_target_next[23:16] = s0_byte_reg;
                    default: held_target_next        = held_target_reg;
                endcase
                pending_count_next = pending_count_reg - 3'd1;
            end
            else
            begin
                // plain byte, possibly a call opcode
                if (s0_byte_reg == CALL_OPCODE && call_ok && !is_end)
                begin
                    pending_count_next = TARGET_BYTES;
                    call_position_next = byte_position_reg;
                    held_target_next   = '0;
                end
                res[0] = '{s0_byte_reg, 1'b1, is_end};
                push_n = 3'd1;
            end
        end
    end

    // Filter state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            pending_count_reg <= '0;
            call_position_reg <= '0;
            held_target_reg   <= '0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            pending_count_reg <= pending_count_next;
            call_position_reg <= call_position_next;
            held_target_reg   <= held_target_next;
        end
    end

    // Output queue storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < push_n)
                q_mem[q_wp_reg + QUEUE_AW'(i)] <= res[i];
        end
    end

    // Output queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg    <= '0;
            q_rp_reg    <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            q_wp_reg    <= q_wp_reg + QUEUE_AW'(push_n);
            q_rp_reg    <= q_rp_reg + QUEUE_AW'(pop);
            q_count_reg <= q_count_reg + (QUEUE_AW+1)'(push_n) - (QUEUE_AW+1)'(pop);
        end
    end

    // Output port
    assign m_tvalid = (q_count_reg != '0);
    assign m_tdata  = q_mem[q_rp_reg].out_byte;
    assign m_tlast  = q_mem[q_rp_reg].run_last;
    assign m_tuser  = q_mem[q_rp_reg].chunk_end;

`ifndef SYNTHESIS
    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("output queue overflow");

    // collection counter stays within a target
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_count_reg <= TARGET_BYTES)
    else $error("pending count out of range");

    // position never reaches the chunk limit
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, byte_position_reg} < 17'(MAX_CHUNK_LENGTH))
    else $error("byte position out of range");

    // a completing target byte pushes a full burst and ends collection
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && pending_count_reg == 3'd1 |=> pending_count_reg == 3'd0
            && q_count_reg >= (QUEUE_AW+1)'(3))
    else $error("target burst not queued");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the E8 call translation filter. Chunks of bytes are
// streamed in, some carrying E8 calls with targets picked around the
// translation boundaries. A scoreboard predicts every output word from its
// own model of the filter, under several direction and file size settings,
// while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import lzx_e8_pkg::*;

    localparam int   LIMIT_CYCLES = 200000;
    localparam int   SETTLE_CYCLES = 8;
    localparam logic DIR_REVERSE = 1'b1;
    // indexes past the last register; writes there must be ignored
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the filter output and checks returned words
    // ------------------------------------------------------------------------
    class e8_scoreboard;
        bit        dir;
        bit [30:0] fsize;
        bit [15:0] position;
        bit [2:0]  need;
        bit [15:0] call_at;
        bit [23:0] held;
        res_t      awaited[$];
        int        errors;
        int        words_seen;
        int        targets_done;

        function new();
            dir = DIR_FORWARD;
            fsize = FILE_SIZE_RESET;
            position = '0;
            need = '0;
            call_at = '0;
            held = '0;
            errors = 0;
            words_seen = 0;
            targets_done = 0;
        endfunction

        function void set_reg(bit [1:0] idx, bit [30:0] val);
            if (idx == REG_DIRECTION)
                dir = val[0];
            else if (idx == REG_FILE_SIZE)
                fsize = val;
        endfunction

        // relative <-> absolute call target for the call at position at
        function bit [31:0] map_target(bit [31:0] tgt, bit [15:0] at);
            longint v;
            longint p;
            longint f;
            longint r;
            v = longint'(signed'(tgt));
            p = at;
            f = fsize;
            r = v;
            if (dir == DIR_FORWARD)
            begin
                if (v >= -p && v < f)
                    r = (v < f - p) ? v + p : v - f;
            end
            else if (v >= 0)
            begin
                if (v < f)
                    r = v - p;
            end
            else if (v >= -p)
            begin
                r = v + f;
            end
            return r[31:0];
        endfunction

        function void push_awaited(bit [7:0] b, bit last, bit cend);
            res_t w;
            w.out_byte = b;
            w.run_last = last;
            w.chunk_end = cend;
            awaited.push_back(w);
        endfunction

        // one accepted input word
        function void note_word(bit [7:0] b, bit [15:0] len_in);
            bit [16:0] len;
            bit [16:0] pos;
            bit        at_end;
            bit [31:0] tgt;
            int        idx;
            len = (len_in > MAX_CHUNK_LENGTH) ? 17'(MAX_CHUNK_LENGTH) : {1'b0, len_in};
            pos = {1'b0, position};
            at_end = (pos + 17'd1 >= len);
            if (need != 0)
            begin
                idx = 4 - need;
                if (need == 3'd1)
                begin
                    // fourth target byte: emit the translated target
                    tgt = map_target({b, held}, call_at);
                    push_awaited(tgt[7:0], 1'b0, 1'b0);
                    push_awaited(tgt[15:8], 1'b0, 1'b0);
                    push_awaited(tgt[23:16], 1'b0, 1'b0);
                    push_awaited(tgt[31:24], 1'b1, at_end);
                    need = '0;
                    held = '0;
                    targets_done++;
                end
                else if (at_end)
                begin
                    // chunk ends mid-target: flush held bytes untouched
                    for (int i = 0; i < idx; i++)
                        push_awaited(held[8*i +: 8], 1'b0, 1'b0);
                    push_awaited(b, 1'b1, 1'b1);
                    need = '0;
                    held = '0;
                end
                else
                begin
                    held[8*idx +: 8] = b;
                    need = need - 3'd1;
                end
            end
            else
            begin
                if (b == CALL_OPCODE && len > TAIL_GUARD && pos + TAIL_GUARD < len && !at_end)
                begin
                    need = TARGET_BYTES;
                    call_at = pos[15:0];
                    held = '0;
                end
                push_awaited(b, 1'b1, at_end);
            end
            position = at_end ? 16'd0 : 16'(pos + 17'd1);
        endfunction

        // one accepted output word
        function void check_word(bit [7:0] b, bit last, bit cend);
            res_t want;
            words_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word byte=%02h last=%0b end=%0b",
                         $time, b, last, cend);
                return;
            end
            want = awaited.pop_front();
            if (want.out_byte !== b)
            begin
                errors++;
                $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte, b);
            end
            if (want.run_last !== last)
            begin
                errors++;
                $display("%0t: run_last expected %0b got %0b", $time, want.run_last, last);
            end
            if (want.chunk_end !== cend)
            begin
                errors++;
                $display("%0t: chunk_end expected %0b got %0b", $time, want.chunk_end, cend);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void finish_check();
            if (awaited.size() != 0)
            begin
                errors++;
                $display("%0t: %0d expected words never arrived, first byte=%02h",
                         $time, awaited.size(), awaited[0].out_byte);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // [7:0] data_byte, [23:8] chunk_length
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;          // run_last
    logic        m_tuser;          // [0] chunk_end

    e8_scoreboard sb;
    int          cycles = 0;
    int          items_sent = 0;
    int          chunks_sent = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          beat = 0;
    bit          cur_dir = DIR_FORWARD;
    bit [30:0]   cur_fs = FILE_SIZE_RESET;

    lzx_e8_call_translation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // monitor: note inputs before checking outputs of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata[7:0], s_tdata[23:8]);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tlast, m_tuser);
        end
    end

    // receiver backpressure: switches between a few stall patterns
    always @(negedge clk)
    begin
        beat++;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (beat % 3 == 0);
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // send one word, inserting a random gap between bursts
    task automatic send_item(input bit [7:0] b, input bit [15:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 7);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk) s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {len, b};
        do @(posedge clk); while (s_tready !== 1'b1);
        items_sent++;
    endtask

    task automatic write_reg(input bit [1:0] idx, input bit [30:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk) cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        if (idx == REG_DIRECTION)
            cur_dir = val[0];
        else if (idx == REG_FILE_SIZE)
            cur_fs = val;
    endtask

    // stop sending and let every expected word drain
    task automatic settle();
        @(negedge clk) s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // call target near the translation boundaries for a call at position at
    function automatic bit [31:0] pick_target(int at);
        longint f;
        longint p;
        longint v;
        f = cur_fs;
        p = at;
        case ($urandom_range(0, 9))
            0:       v = $urandom;
            1:       v = -p;
            2:       v = -p - 1;
            3:       v = f - p - 1;
            4:       v = f - p;
            5:       v = f - 1;
            6:       v = f;
            7:       v = $urandom_range(0, 255);
            8:       v = -longint'($urandom_range(1, 64));
            default: v = $urandom_range(0, cur_fs);
        endcase
        return v[31:0];
    endfunction

    // one chunk; the last word carries len_last so chunks can be cut short
    task automatic send_chunk(input int nbytes, input bit [15:0] len_mid,
                              input bit [15:0] len_last, input bit plant);
        int        i;
        bit [31:0] tgt;
        i = 0;
        while (i < nbytes)
        begin
            if (plant && i + 5 <= nbytes && $urandom_range(0, 9) < 4)
            begin
                tgt = pick_target(i);
                send_item(CALL_OPCODE, len_mid);
                for (int k = 0; k < 4; k++)
                    send_item(tgt[8*k +: 8], (i + 1 + k == nbytes - 1) ? len_last : len_mid);
                i += 5;
            end
            else
            begin
                send_item(($urandom_range(0, 9) == 0) ? CALL_OPCODE : 8'($urandom),
                          (i == nbytes - 1) ? len_last : len_mid);
                i++;
            end
        end
        chunks_sent++;
    endtask

    task automatic run_directed();
        // zero length: every word ends a chunk
        send_item(CALL_OPCODE, 16'd0);
        send_item(8'h00, 16'd0);
        // short chunk, no translation
        send_item(CALL_OPCODE, 16'd6);
        send_item(8'h78, 16'd6);
        send_item(8'h56, 16'd6);
        send_item(8'h34, 16'd6);
        send_item(8'h12, 16'd6);
        send_item(8'hFF, 16'd6);
        // saturated length, target completes on the chunk's last word
        send_item(8'hFF, 16'hFFFF);
        send_item(CALL_OPCODE, 16'hFFFF);
        send_item(8'hFF, 16'hFFFF);
        send_item(8'hFF, 16'hFFFF);
        send_item(8'hFF, 16'hFFFF);
        send_item(8'hFF, 16'd1);
        // target cut when the chunk ends
        send_item(CALL_OPCODE, 16'd40000);
        send_item(8'h11, 16'd40000);
        send_item(8'h22, 16'd0);
        // smallest chunk that translates
        send_item(CALL_OPCODE, 16'd11);
        send_item(8'h10, 16'd11);
        send_item(8'h00, 16'd11);
        send_item(8'h00, 16'd11);
        send_item(8'h00, 16'd11);
        for (int k = 0; k < 6; k++)
            send_item((k % 2) ? 8'hFF : 8'h00, 16'd11);
        chunks_sent += 6;
    endtask

    task automatic run_random(input int quota);
        int start;
        int n;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            case ($urandom_range(0, 9))
                6:
                begin
                    n = $urandom_range(1, 10);
                    send_chunk(n, 16'(n), 16'(n), 1'b1);
                end
                7:
                begin
                    n = $urandom_range(1, 12);
                    send_chunk(n, 16'($urandom_range(16, 65535)),
                               16'($urandom_range(0, 1)), 1'b1);
                end
                8:
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_item($urandom_range(0, 1) ? CALL_OPCODE : 8'($urandom), 16'd0);
                        chunks_sent++;
                    end
                end
                9:
                begin
                    n = $urandom_range(11, 30);
                    send_chunk(n, 16'(n), 16'(n), 1'b0);
                end
                default:
                begin
                    n = $urandom_range(11, 40);
                    send_chunk(n, 16'(n), 16'(n), 1'b1);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // reset settings
        run_directed();
        run_random(18);

        settle();
        write_reg(REG_DIRECTION, DIR_REVERSE);
        run_random(18);

        settle();
        write_reg(REG_DIRECTION, DIR_FORWARD);
        write_reg(REG_FILE_SIZE, 31'd1);
        run_random(18);

        settle();
        write_reg(REG_DIRECTION, DIR_REVERSE);
        write_reg(REG_FILE_SIZE, 31'h7FFF_FFFF);
        run_random(18);

        // zero file size, plus writes to unused indexes
        settle();
        write_reg(REG_DIRECTION, DIR_FORWARD);
        write_reg(REG_FILE_SIZE, 31'd0);
        write_reg(REG_SPARE_2, 31'h7FFF_FFFF);
        write_reg(REG_SPARE_3, 31'd5);
        run_random(18);

        settle();
        write_reg(REG_DIRECTION, DIR_REVERSE);
        write_reg(REG_FILE_SIZE, 31'd100);
        run_random(18);

        settle();
        write_reg(REG_DIRECTION, DIR_FORWARD);
        write_reg(REG_FILE_SIZE, 31'($urandom_range(20, 5000)));
        run_random(18);

        settle();
        sb.finish_check();
        $display("covered %0d input words in %0d chunks, %0d output words, %0d targets",
                 items_sent, chunks_sent, sb.words_seen, sb.targets_done);
        $display("both directions, file sizes 0, 1, 100, 12000000, 2^31-1 and one random");
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
